FILE: rtl/mlr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlr_pkg - shared types and constants of the midpoint line rasterizer
// Coordinate widths, request codes, channel item structs and the line setup
// record that goes from the setup logic to the walker.
// ----------------------------------------------------------------------------
package mlr_pkg;

	localparam int COORD_BITS = 12;
	// decision term spans about +/- 2*(2^COORD_BITS - 1): two bits plus sign
	localparam int DEC_BITS   = COORD_BITS + 3;

	typedef logic [COORD_BITS-1:0]      coord_t;
	typedef logic signed [DEC_BITS-1:0] dec_t;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	typedef struct packed {
		logic   req_type;
		coord_t x_start;
		coord_t y_start;
		coord_t x_end;
		coord_t y_end;
	} cmd_t;

	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		logic   pixel_valid;
		logic   last_pixel;
	} pix_t;

	typedef struct packed {
		coord_t major0;
		coord_t minor0;
		coord_t end_major;
		coord_t delta_major;
		coord_t delta_minor;
		dec_t   decision;
		logic   minor_dir_down;
		logic   y_is_major;
		logic   active;
	} line_setup_t;

endpackage : mlr_pkg
`default_nettype wire

FILE: rtl/mlr_setup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlr_setup - line setup
// Picks the major axis, orders the endpoints along it and forms the spans,
// the minor direction and the initial midpoint decision term.
// ----------------------------------------------------------------------------
module mlr_setup (
	input  wire mlr_pkg::cmd_t   cmd,
	output mlr_pkg::line_setup_t setup
);

	mlr_pkg::coord_t dx;
	mlr_pkg::coord_t dy;
	mlr_pkg::coord_t ma0, mi0, ma1, mi1;
	mlr_pkg::coord_t lo_major, lo_minor, hi_major, hi_minor;
	mlr_pkg::coord_t d_major, d_minor;
	logic            y_major;
	logic            swap;

	always_comb begin
		dx = (cmd.x_start >= cmd.x_end) ? cmd.x_start - cmd.x_end : cmd.x_end - cmd.x_start;
		dy = (cmd.y_start >= cmd.y_end) ? cmd.y_start - cmd.y_end : cmd.y_end - cmd.y_start;
		y_major = (dy >= dx);

		if (y_major) begin
			ma0 = cmd.y_start;
			mi0 = cmd.x_start;
			ma1 = cmd.y_end;
			mi1 = cmd.x_end;
		end else begin
			ma0 = cmd.x_start;
			mi0 = cmd.y_start;
			ma1 = cmd.x_end;
			mi1 = cmd.y_end;
		end

		// tie keeps the first endpoint as the start
		swap     = (ma1 < ma0);
		lo_major = swap ? ma1 : ma0;
		lo_minor = swap ? mi1 : mi0;
		hi_major = swap ? ma0 : ma1;
		hi_minor = swap ? mi0 : mi1;

		d_major = hi_major - lo_major;
		d_minor = (lo_minor >= hi_minor) ? lo_minor - hi_minor : hi_minor - lo_minor;

		setup.major0         = lo_major;
		setup.minor0         = lo_minor;
		setup.end_major      = hi_major;
		setup.delta_major    = d_major;
		setup.delta_minor    = d_minor;
		setup.decision       = $signed({2'b00, d_minor, 1'b0}) - $signed({3'b000, d_major});
		setup.minor_dir_down = (hi_minor < lo_minor);
		setup.y_is_major     = y_major;
		setup.active         = (d_major != '0);
	end

endmodule : mlr_setup
`default_nettype wire

FILE: rtl/mlr_walker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlr_walker - line state and per-pixel step
// Holds the running line position and decision term. A load takes a new
// setup; a step emits the current pixel and advances one major unit.
// ----------------------------------------------------------------------------
module mlr_walker (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         adv,
	input  wire                         step,
	input  wire mlr_pkg::line_setup_t   setup,
	output mlr_pkg::pix_t               pix
);

	mlr_pkg::coord_t cur_major_q;
	mlr_pkg::coord_t cur_minor_q;
	mlr_pkg::coord_t end_major_q;
	mlr_pkg::coord_t delta_major_q;
	mlr_pkg::coord_t delta_minor_q;
	mlr_pkg::dec_t   decision_q;
	logic            minor_dir_down_q;
	logic            y_is_major_q;
	logic            active_q;

	mlr_pkg::coord_t major_inc;
	mlr_pkg::coord_t minor_next;
	mlr_pkg::dec_t   dec_next;
	logic            move_minor;
	logic            emit;

	always_comb begin
		emit       = step && active_q;
		major_inc  = cur_major_q + 1'b1;
		move_minor = (decision_q > 0);
		minor_next = minor_dir_down_q ? cur_minor_q - 1'b1 : cur_minor_q + 1'b1;
		dec_next   = decision_q + $signed({2'b00, delta_minor_q, 1'b0})
			- (move_minor ? $signed({2'b00, delta_major_q, 1'b0}) : '0);

		pix.pixel_valid = emit;
		pix.pixel_x     = '0;
		pix.pixel_y     = '0;
		pix.last_pixel  = 1'b0;
		if (emit) begin
			pix.pixel_x    = y_is_major_q ? cur_minor_q : cur_major_q;
			pix.pixel_y    = y_is_major_q ? cur_major_q : cur_minor_q;
			pix.last_pixel = ({1'b0, cur_major_q} + 1'b1) == {1'b0, end_major_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_major_q      <= '0;
			cur_minor_q      <= '0;
			end_major_q      <= '0;
			delta_major_q    <= '0;
			delta_minor_q    <= '0;
			decision_q       <= '0;
			minor_dir_down_q <= 1'b0;
			y_is_major_q     <= 1'b0;
			active_q         <= 1'b0;
		end else if (adv && !step) begin
			cur_major_q      <= setup.major0;
			cur_minor_q      <= setup.minor0;
			end_major_q      <= setup.end_major;
			delta_major_q    <= setup.delta_major;
			delta_minor_q    <= setup.delta_minor;
			decision_q       <= setup.decision;
			minor_dir_down_q <= setup.minor_dir_down;
			y_is_major_q     <= setup.y_is_major;
			active_q         <= setup.active;
		end else if (adv && emit) begin
			cur_major_q <= major_inc;
			if (move_minor) begin
				cur_minor_q <= minor_next;
			end
			decision_q <= dec_next;
			if (major_inc == end_major_q) begin
				active_q <= 1'b0;
			end
		end
	end

endmodule : mlr_walker
`default_nettype wire

FILE: rtl/midpoint_line_rasterizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer - midpoint line pixel generator
// Three-register pipeline: command register, line setup register, result
// register, with the running line state in the walker.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd): each item is a load
//   (req_type = REQ_LOAD) with two endpoints, or a step (REQ_STEP).
//   res channel (res_valid/res_ready/res): exactly one result item per
//   command item, in order. A load answers with all fields zero; a step
//   answers with the next pixel (pixel_valid = 1, last_pixel on the final
//   one), or all zeros when no line is active. The far endpoint is not drawn.
//   Path: a command accepted into the command register moves through the line
//   setup register to the result register (three registers in the path).
//   Throughput: one item per clock unless stalled; the step loop is one
//   add/compare on the decision term and one increment of the major coordinate.
//   Each stage fills whenever the stage ahead is empty or moving, so while a
//   result waits the pipe still takes items until all three stages hold one;
//   then cmd_ready drops until res_ready returns.
//   Reset: all stages empty, line state cleared, no line active.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cmd_valid,
	output logic               cmd_ready,
	input  wire mlr_pkg::cmd_t cmd,
	output logic               res_valid,
	input  wire                res_ready,
	output mlr_pkg::pix_t      res
);

	// stage occupancy
	logic v_s1, v_s2;
	logic res_valid_q;

	// stage payloads
	mlr_pkg::cmd_t        cmd_s1;
	logic                 step_s2;
	mlr_pkg::line_setup_t setup_s2;
	mlr_pkg::pix_t        res_q;

	mlr_pkg::line_setup_t setup_c;
	mlr_pkg::pix_t        pix_c;

	logic adv1, adv2, adv3;

	// each stage may load when it is empty or its item moves on
	assign adv3      = !res_valid_q || res_ready;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign cmd_ready = adv1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	mlr_setup u_setup (
		.cmd   (cmd_s1),
		.setup (setup_c)
	);

	// line state advances when the item in stage 2 moves to the result register
	mlr_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (v_s2 && adv3),
		.step   (step_s2),
		.setup  (setup_s2),
		.pix    (pix_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= cmd_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				res_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && cmd_valid) begin
			cmd_s1 <= cmd;
		end
		if (adv2 && v_s1) begin
			step_s2  <= (cmd_s1.req_type == mlr_pkg::REQ_STEP);
			setup_s2 <= setup_c;
		end
		if (adv3 && v_s2) begin
			res_q <= pix_c;
		end
	end

	// last pixel only ever flagged on a real pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last_pixel |-> res.pixel_valid)
		else $error("last_pixel without pixel_valid");

	// an empty result register never blocks the command side
	assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> cmd_ready)
		else $error("cmd_ready low with empty result register");

	// a full, stalled pipe must refuse new commands
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_ready && v_s2 && v_s1 |-> !cmd_ready)
		else $error("command accepted into full stalled pipe");

	// a load item always answers with pixel_valid and last_pixel low
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && adv3 && !step_s2 |=> res_valid && !res.pixel_valid && !res.last_pixel)
		else $error("load produced a pixel");

endmodule : midpoint_line_rasterizer
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench of the midpoint line rasterizer
// Sends load and step items on the cmd channel and checks every result item
// against an in-bench midpoint line walker. Directed lines cover the extreme
// coordinates, degenerate and one-pixel lines, decision ties and steps while
// idle; random lines follow, with random idling on both channels, a long
// receiver hold-off and a full drain between phases.
// ----------------------------------------------------------------------------
module tb;

	localparam int ITEM_TARGET = 750;
	localparam int IDLE_PCT    = 14;
	localparam int STALL_LEN   = 90;   // receiver hold-off, in cycles
	localparam int TAIL_CYCLES = 6;    // three registers in the path, plus margin

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           cmd_valid = 1'b0;
	mlr_pkg::cmd_t  cmd       = '0;
	logic           res_ready = 1'b0;
	logic           cmd_ready;
	logic           res_valid;
	mlr_pkg::pix_t  res;

	midpoint_line_rasterizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Line walker: own copy of the running line state
	// ------------------------------------------------------------------------
	mlr_pkg::coord_t walk_major;
	mlr_pkg::coord_t walk_minor;
	mlr_pkg::coord_t walk_end;
	mlr_pkg::coord_t walk_dmaj;
	mlr_pkg::coord_t walk_dmin;
	mlr_pkg::dec_t   walk_dec;
	logic            walk_down;
	logic            walk_y_major;
	logic            walk_active;

	initial begin
		walk_major   = '0;
		walk_minor   = '0;
		walk_end     = '0;
		walk_dmaj    = '0;
		walk_dmin    = '0;
		walk_dec     = '0;
		walk_down    = 1'b0;
		walk_y_major = 1'b0;
		walk_active  = 1'b0;
	end

	mlr_pkg::pix_t pixel_q[$];   // pixels (or zero items) still owed by the block

	int errors      = 0;
	int sent        = 0;
	int n_loads     = 0;
	int n_pixels    = 0;
	int n_lines     = 0;
	int n_idle_step = 0;

	// shared knobs: calm turns off random idling on both sides, stall_req asks
	// the receiver for one long hold-off
	logic calm      = 1'b0;
	logic stall_req = 1'b0;
	int   stall_left = 0;

	function automatic mlr_pkg::coord_t span(mlr_pkg::coord_t a, mlr_pkg::coord_t b);
		return (a >= b) ? mlr_pkg::coord_t'(a - b) : mlr_pkg::coord_t'(b - a);
	endfunction

	// Advance the walker by one command item, return the result it owes.
	function automatic mlr_pkg::pix_t rasterize_item(mlr_pkg::cmd_t c);
		mlr_pkg::pix_t   p;
		mlr_pkg::coord_t dx, dy, ma0, mi0, ma1, mi1, t;
		p = '0;
		if (c.req_type == mlr_pkg::REQ_LOAD) begin
			dx = span(c.x_start, c.x_end);
			dy = span(c.y_start, c.y_end);
			// y wins a tie between the spans
			walk_y_major = (dy >= dx);
			if (walk_y_major) begin
				ma0 = c.y_start; mi0 = c.x_start; ma1 = c.y_end; mi1 = c.x_end;
			end else begin
				ma0 = c.x_start; mi0 = c.y_start; ma1 = c.x_end; mi1 = c.y_end;
			end
			// walk from the smaller major coordinate; equal keeps the first endpoint
			if (ma1 < ma0) begin
				t = ma0; ma0 = ma1; ma1 = t;
				t = mi0; mi0 = mi1; mi1 = t;
			end
			walk_major  = ma0;
			walk_minor  = mi0;
			walk_end    = ma1;
			walk_dmaj   = mlr_pkg::coord_t'(ma1 - ma0);
			walk_dmin   = span(mi0, mi1);
			walk_down   = (mi1 < mi0);
			walk_dec    = mlr_pkg::dec_t'(2 * int'(walk_dmin) - int'(walk_dmaj));
			walk_active = (walk_dmaj != '0);
		end else if (walk_active) begin
			p.pixel_x     = walk_y_major ? walk_minor : walk_major;
			p.pixel_y     = walk_y_major ? walk_major : walk_minor;
			p.pixel_valid = 1'b1;
			p.last_pixel  = (int'(walk_major) + 1 == int'(walk_end));
			// zero decision keeps the minor coordinate
			if (walk_dec > 0) begin
				walk_minor = walk_down ? mlr_pkg::coord_t'(walk_minor - 1'b1)
				                       : mlr_pkg::coord_t'(walk_minor + 1'b1);
				walk_dec   = mlr_pkg::dec_t'(int'(walk_dec) - 2 * int'(walk_dmaj));
			end
			walk_dec   = mlr_pkg::dec_t'(int'(walk_dec) + 2 * int'(walk_dmin));
			walk_major = mlr_pkg::coord_t'(walk_major + 1'b1);
			if (walk_major == walk_end)
				walk_active = 1'b0;
		end
		return p;
	endfunction

	task automatic check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Scoreboard: predict on every accepted cmd item, check every result item.
	// Both sample pre-edge values, since all drivers use nonblocking updates.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		mlr_pkg::pix_t exp_p;
		if (arst_n) begin
			if (cmd_valid && cmd_ready) begin
				exp_p = rasterize_item(cmd);
				if (cmd.req_type == mlr_pkg::REQ_LOAD)
					n_loads++;
				else if (!exp_p.pixel_valid)
					n_idle_step++;
				pixel_q = {pixel_q, exp_p};
			end
			if (res_valid && res_ready) begin
				if (pixel_q.size() == 0) begin
					$display("%0t: result item with nothing expected, actual x=%0d y=%0d v=%0b l=%0b",
					         $time, res.pixel_x, res.pixel_y, res.pixel_valid, res.last_pixel);
					errors++;
				end else begin
					exp_p = pixel_q.pop_front();
					check_field("pixel_x", exp_p.pixel_x, res.pixel_x);
					check_field("pixel_y", exp_p.pixel_y, res.pixel_y);
					check_field("pixel_valid", exp_p.pixel_valid, res.pixel_valid);
					check_field("last_pixel", exp_p.last_pixel, res.last_pixel);
					if (exp_p.pixel_valid)
						n_pixels++;
					if (exp_p.last_pixel)
						n_lines++;
				end
			end
		end
	end

	// Receiver: random idling, or one long hold-off on request.
	always @(posedge clk) begin
		if (stall_req) begin
			stall_left = STALL_LEN;
			stall_req  = 1'b0;
		end
		if (stall_left > 0) begin
			stall_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// ------------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------------

	// Offer one item, with a random gap ahead of it; returns at the accepting
	// edge with valid still high, so back-to-back items need no re-raise.
	task automatic send_cmd(mlr_pkg::cmd_t c);
		if (!calm && $urandom_range(0, 99) < IDLE_PCT - 2) begin
			cmd_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 25);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		sent++;
	endtask

	function automatic mlr_pkg::cmd_t load_cmd(int xs, int ys, int xe, int ye);
		mlr_pkg::cmd_t c;
		c.req_type = mlr_pkg::REQ_LOAD;
		c.x_start  = mlr_pkg::coord_t'(xs);
		c.y_start  = mlr_pkg::coord_t'(ys);
		c.x_end    = mlr_pkg::coord_t'(xe);
		c.y_end    = mlr_pkg::coord_t'(ye);
		return c;
	endfunction

	// step items carry junk endpoints, which the block must ignore
	function automatic mlr_pkg::cmd_t step_cmd();
		mlr_pkg::cmd_t c;
		c.req_type = mlr_pkg::REQ_STEP;
		c.x_start  = mlr_pkg::coord_t'($urandom);
		c.y_start  = mlr_pkg::coord_t'($urandom);
		c.x_end    = mlr_pkg::coord_t'($urandom);
		c.y_end    = mlr_pkg::coord_t'($urandom);
		return c;
	endfunction

	task automatic send_steps(int n);
		repeat (n) send_cmd(step_cmd());
	endtask

	// Drop valid and wait until every owed result has come back. The first
	// edge lets the scoreboard log an item accepted at the current edge.
	task automatic wait_results();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pixel_q.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// nothing loaded yet: steps give all-zero items
	task automatic test_idle_steps();
		send_steps(2);
	endtask

	// corner endpoints; each new load abandons the line in progress
	task automatic test_extreme_lines();
		send_cmd(load_cmd(0, 0, 4095, 4095));
		send_steps(3);
		// equal spans put y on the major axis; x runs down from 4095
		send_cmd(load_cmd(4095, 0, 0, 4095));
		send_steps(3);
	endtask

	// same point twice draws nothing; a one-pixel line ends right away
	task automatic test_degenerate();
		send_cmd(load_cmd(4095, 4095, 4095, 4095));
		send_steps(1);
		send_cmd(load_cmd(4095, 4095, 4094, 4095));
		send_steps(2);
	endtask

	// dx = 4, dy = 2 starts the decision at exactly zero
	task automatic test_decision_tie();
		send_cmd(load_cmd(10, 20, 14, 22));
		send_steps(4);
		// same line given back to front
		send_cmd(load_cmd(14, 22, 10, 20));
		send_steps(4);
	endtask

	// receiver holds off while the sender keeps offering, so the pipe fills
	// and cmd_ready drops; then the sender pauses until all is drained
	task automatic test_backpressure();
		calm      = 1'b1;
		stall_req = 1'b1;
		send_cmd(load_cmd(100, 200, 130, 190));
		send_steps(24);
		calm = 1'b0;
		wait_results();
	endtask

	function automatic int pick_coord();
		case ($urandom_range(0, 3))
			0:       return $urandom_range(0, 30);
			1:       return $urandom_range(4065, 4095);
			default: return $urandom_range(0, 4095);
		endcase
	endfunction

	function automatic int near_coord(int a);
		int d;
		d = $urandom_range(0, 20);
		if ($urandom_range(0, 1))
			d = -d;
		if (a + d < 0 || a + d > 4095)
			d = -d;
		return a + d;
	endfunction

	// One random line: mostly loaded and walked to the end (a few extra
	// steps run idle), some abandoned midway, some preceded by stray steps.
	task automatic draw_random_line();
		int x0, y0, x1, y1, n, steps, mode;
		x0 = pick_coord();
		y0 = pick_coord();
		if ($urandom_range(0, 15) == 0) begin
			x1 = $urandom_range(0, 4095);
			y1 = $urandom_range(0, 4095);
		end else begin
			x1 = near_coord(x0);
			y1 = near_coord(y0);
		end
		n = (x1 > x0) ? x1 - x0 : x0 - x1;
		if (((y1 > y0) ? y1 - y0 : y0 - y1) > n)
			n = (y1 > y0) ? y1 - y0 : y0 - y1;
		mode = $urandom_range(0, 9);
		if (mode == 9)
			send_steps($urandom_range(1, 3));
		if (n > 40)
			steps = $urandom_range(0, 12);
		else if (mode < 7)
			steps = n + $urandom_range(0, 2);
		else
			steps = $urandom_range(0, n);
		send_cmd(load_cmd(x0, y0, x1, y1));
		send_steps(steps);
	endtask

	task automatic test_random_lines();
		while (sent < ITEM_TARGET) begin
			// a stretch with no idling on either side
			calm = (sent >= 300 && sent < 420);
			draw_random_line();
		end
		calm = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_steps();
		test_extreme_lines();
		test_degenerate();
		test_decision_tie();
		wait_results();
		test_backpressure();
		test_random_lines();
		wait_results();

		if (pixel_q.size() != 0) begin
			$display("%0t: %0d result items never arrived", $time, pixel_q.size());
			errors++;
		end
		$display("covered %0d items: %0d loads, %0d pixels, %0d lines drawn to the end",
		         sent, n_loads, n_pixels, n_lines);
		$display("%0d steps while idle, %0d mismatches", n_idle_step, errors);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// run limit, far above a correct run
	initial begin
		#5000000;
		$display("timeout at %0t", $time);
		$display("tb failed");
		$finish;
	end

endmodule
